// ===== rtl/cke_pkg.sv =====
// Shared types, constants and the base decoder for the canonical k-mer encoder.
package cke_pkg;

    localparam int MAX_KMER_LENGTH = 32;
    localparam int KLEN_W          = 6;
    localparam int KMER_W          = 2 * MAX_KMER_LENGTH;
    localparam int CHAR_W          = 8;

    localparam logic [KLEN_W-1:0] KMER_LENGTH_RESET = KLEN_W'(22);
    localparam logic [KLEN_W-1:0] KLEN_MAX          = KLEN_W'(MAX_KMER_LENGTH);

    typedef logic [KLEN_W-1:0] klen_t;
    typedef logic [KMER_W-1:0] kmer_t;
    typedef logic [1:0]        base_t;

    // Rolling window state carried between words.
    typedef struct packed {
        kmer_t fwd;
        kmer_t rev;
        klen_t run;
    } win_t;

    typedef struct packed {
        logic  ok;
        base_t code;
    } base_dec_t;

    localparam win_t WIN_CLEAR = '{fwd: '0, rev: '0, run: '0};

    function automatic base_dec_t decode_base(logic [CHAR_W-1:0] ch);
        base_dec_t d;
        d.ok   = 1'b1;
        d.code = 2'd0;
        case (ch)
            "A", "a": d.code = 2'd0;
            "C", "c": d.code = 2'd1;
            "G", "g": d.code = 2'd2;
            "T", "t": d.code = 2'd3;
            default:  d.ok   = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/cke_step.sv =====
// One-base window update and canonical selection.
module cke_step (
    input  cke_pkg::win_t                     win,
    input  cke_pkg::klen_t                    k_eff,
    input  logic [cke_pkg::CHAR_W-1:0]        nucleotide_char,
    input  logic                              sequence_start,
    output cke_pkg::win_t                     win_next,
    output logic                              emit,
    output cke_pkg::kmer_t                    kmer,
    output logic                              from_rev
);
    import cke_pkg::*;

    win_t      base_win;
    base_dec_t dec;
    kmer_t     mask;
    base_t     comp_code;
    kmer_t     comp_shifted;
    klen_t     k_minus1;
    klen_t     run_inc;

    always_comb
    begin
        base_win  = sequence_start ? WIN_CLEAR : win;
        dec       = decode_base(nucleotide_char);
        k_minus1  = k_eff - klen_t'(1);
        comp_code = ~dec.code;

        if (k_eff >= KLEN_MAX)
            mask = '1;
        else
            mask = (kmer_t'(1) << {k_eff, 1'b0}) - kmer_t'(1);

        // Complement base enters at the top of the k-base window.
        comp_shifted = kmer_t'(comp_code) << {k_minus1[KLEN_W-2:0], 1'b0};
        run_inc      = (base_win.run < KLEN_MAX) ? base_win.run + klen_t'(1)
                                                 : base_win.run;

        if (dec.ok)
        begin
            win_next.fwd = ((base_win.fwd << 2) | kmer_t'(dec.code)) & mask;
            win_next.rev = ((base_win.rev & mask) >> 2) | comp_shifted;
            win_next.run = run_inc;
        end
        else
        begin
            win_next = WIN_CLEAR;
        end

        emit     = dec.ok && (win_next.run >= k_eff);
        from_rev = win_next.rev < win_next.fwd;
        kmer     = from_rev ? win_next.rev : win_next.fwd;
    end

endmodule

// ===== rtl/canonical_kmer_encoder_core.sv =====
// Top level of the canonical k-mer encoder: window state, config and result register.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  input    | in_valid / in_ready       | nucleotide_char[7:0], sequence_start
//  output   | out_valid / out_ready     | canonical_kmer[63:0], from_reverse
//  config   | cfg_we                    | cfg_wdata[5:0] (kmer_length)
//
// One word per cycle: the window shift and compare sit between the window
// registers and the result register, so a result appears in the cycle after its
// word is taken. in_ready drops only while a result is held and out_ready is low.
// Reset (rst_n low, asynchronous) clears the windows and sets kmer_length to 22.
module canonical_kmer_encoder_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cke_pkg::CHAR_W-1:0]   nucleotide_char,
    input  logic                         sequence_start,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cke_pkg::KMER_W-1:0]   canonical_kmer,
    output logic                         from_reverse,
    input  logic                         cfg_we,
    input  logic [cke_pkg::KLEN_W-1:0]   cfg_wdata
);
    import cke_pkg::*;

    klen_t klen_reg;
    win_t  win_reg;
    win_t  win_next;
    klen_t k_eff;
    logic  emit;
    kmer_t kmer;
    logic  from_rev;
    logic  out_valid_reg;
    kmer_t kmer_reg;
    logic  from_rev_reg;
    logic  in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Clamp k into 1..MAX_KMER_LENGTH.
    always_comb
    begin
        if (klen_reg == '0)
            k_eff = klen_t'(1);
        else if (klen_reg > KLEN_MAX)
            k_eff = KLEN_MAX;
        else
            k_eff = klen_reg;
    end

    cke_step u_step (
        .win             (win_reg),
        .k_eff           (k_eff),
        .nucleotide_char (nucleotide_char),
        .sequence_start  (sequence_start),
        .win_next        (win_next),
        .emit            (emit),
        .kmer            (kmer),
        .from_rev        (from_rev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            klen_reg      <= KMER_LENGTH_RESET;
            win_reg       <= WIN_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                klen_reg <= cfg_wdata;
                win_reg  <= WIN_CLEAR;
            end
            else if (in_fire)
            begin
                win_reg <= win_next;
            end

            if (in_fire)
                out_valid_reg <= emit;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Load the result only when a word is taken and emits a k-mer; hold it otherwise.
    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            kmer_reg     <= kmer;
            from_rev_reg <= from_rev;
        end
    end

    assign out_valid      = out_valid_reg;
    assign canonical_kmer = kmer_reg;
    assign from_reverse   = from_rev_reg;

endmodule
